// ===== hw/rtl/gnd_pkg.sv =====
// shared types, constants and the 3x3 offset table for the neighbourhood diff block
// no dependencies; used by every module of the block
`default_nettype none

package gnd_pkg;

  // grid size limit that the configured dimensions saturate to
  localparam int unsigned GridDim = 256;

  // field widths
  localparam int unsigned CoordW = 8;
  localparam int unsigned DimW   = 9;
  localparam int unsigned EffW   = 10;

  // one bit per candidate cell: nine entering, then nine leaving
  localparam int unsigned NbrCells = 9;
  localparam int unsigned MaskW    = 2 * NbrCells;
  localparam int unsigned IdxW     = 5;

  // default depth of the job queue between front and back
  localparam int unsigned DefFifoDepth = 4;

  // configuration register indexes
  typedef enum logic [0:0] {
    RegSectorsAcross = 1'b0,
    RegSectorsDown   = 1'b1
  } gnd_reg_e;

  typedef logic [MaskW-1:0] gnd_mask_t;

  // one classified move, as queued between front and back
  typedef struct packed {
    logic [CoordW-1:0] old_col;
    logic [CoordW-1:0] old_row;
    logic [CoordW-1:0] new_col;
    logic [CoordW-1:0] new_row;
    gnd_mask_t         mask;
  } gnd_job_t;

  // column and row offsets, stored as offset plus one
  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
  } gnd_off_t;

  // row-major walk of the 3x3 neighbourhood
  function automatic gnd_off_t cell_off(input logic [3:0] k);
    gnd_off_t o;
    case (k)
      4'd0:    o = '{dx: 2'd0, dy: 2'd0};
      4'd1:    o = '{dx: 2'd1, dy: 2'd0};
      4'd2:    o = '{dx: 2'd2, dy: 2'd0};
      4'd3:    o = '{dx: 2'd0, dy: 2'd1};
      4'd4:    o = '{dx: 2'd1, dy: 2'd1};
      4'd5:    o = '{dx: 2'd2, dy: 2'd1};
      4'd6:    o = '{dx: 2'd0, dy: 2'd2};
      4'd7:    o = '{dx: 2'd1, dy: 2'd2};
      4'd8:    o = '{dx: 2'd2, dy: 2'd2};
      default: o = '{dx: 2'd1, dy: 2'd1};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gnd_front.sv =====
// front end: grid size registers and classification of each move into a cell mask
// depends on gnd_pkg
`default_nettype none

module gnd_front
  import gnd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration writes
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [DimW-1:0]   cfg_wdata_i,
  // incoming moves
  input  wire logic              push_i,
  input  wire logic [CoordW-1:0] old_col_i,
  input  wire logic [CoordW-1:0] old_row_i,
  input  wire logic [CoordW-1:0] new_col_i,
  input  wire logic [CoordW-1:0] new_row_i,
  // job queue write side
  input  wire logic              q_full_i,
  output logic                   q_wr_o,
  output gnd_job_t               q_job_o
);

  logic [DimW-1:0] across_q;
  logic [DimW-1:0] down_q;
  logic [EffW-1:0] across_eff;
  logic [EffW-1:0] down_eff;
  gnd_mask_t       mask;

  // grid size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= DimW'(1);
      down_q   <= DimW'(1);
    end else if (cfg_we_i) begin
      case (gnd_reg_e'(cfg_idx_i))
        RegSectorsAcross: across_q <= cfg_wdata_i;
        RegSectorsDown:   down_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturate to the grid limit
  always_comb begin
    if (32'(across_q) > GridDim) across_eff = EffW'(GridDim);
    else                         across_eff = {1'b0, across_q};
    if (32'(down_q) > GridDim)   down_eff = EffW'(GridDim);
    else                         down_eff = {1'b0, down_q};
  end

  // mark cells of each neighbourhood that lie in the grid and outside the other one
  always_comb begin : p_mask
    logic [CoordW-1:0] cc;
    logic [CoordW-1:0] cr;
    logic [CoordW-1:0] oc;
    logic [CoordW-1:0] orow;
    logic [EffW-1:0]   x;
    logic [EffW-1:0]   y;
    logic              near_x;
    logic              near_y;
    gnd_off_t          off;
    mask = '0;
    for (int g = 0; g < 2; g++) begin
      cc   = (g == 0) ? new_col_i : old_col_i;
      cr   = (g == 0) ? new_row_i : old_row_i;
      oc   = (g == 0) ? old_col_i : new_col_i;
      orow = (g == 0) ? old_row_i : new_row_i;
      for (int k = 0; k < NbrCells; k++) begin
        off = cell_off(4'(k));
        // minus one wraps to all ones, which the size compare rejects
        x = {2'b0, cc} + EffW'(off.dx) - EffW'(1);
        y = {2'b0, cr} + EffW'(off.dy) - EffW'(1);
        near_x = (x + EffW'(1) >= {2'b0, oc}) && (x <= {2'b0, oc} + EffW'(1));
        near_y = (y + EffW'(1) >= {2'b0, orow}) && (y <= {2'b0, orow} + EffW'(1));
        mask[g*NbrCells + k] = (x < across_eff) && (y < down_eff) && !(near_x && near_y);
      end
    end
  end

  // moves with nothing to report are dropped here
  assign q_wr_o  = push_i && !q_full_i && (|mask);
  assign q_job_o = '{old_col: old_col_i, old_row: old_row_i,
                     new_col: new_col_i, new_row: new_row_i, mask: mask};

endmodule

`default_nettype wire

// ===== hw/rtl/gnd_fifo.sv =====
// small flop-based job queue between the front and back ends
// depends on gnd_pkg
`default_nettype none

module gnd_fifo
  import gnd_pkg::*;
#(
  parameter int unsigned Depth = DefFifoDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_i,
  input  wire gnd_job_t wdata_i,
  output logic          full_o,
  input  wire logic     rd_i,
  output gnd_job_t      rdata_o,
  output logic          valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gnd_job_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gnd_back.sv =====
// back end: walks the cell mask of each queued job, one result per cycle while results are taken
// depends on gnd_pkg
`default_nettype none

module gnd_back
  import gnd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // job queue read side
  input  wire logic              q_valid_i,
  input  wire gnd_job_t          q_job_i,
  output logic                   q_rd_o,
  // result queue view
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [CoordW-1:0]      cell_col_o,
  output logic [CoordW-1:0]      cell_row_o,
  output logic                   leaving_o,
  output logic                   last_o
);

  gnd_job_t          job_q;
  logic              busy_q;
  logic              out_valid_q;
  logic              adv;
  logic              emit;
  logic              load;
  gnd_mask_t         low;
  gnd_mask_t         rem;
  logic [IdxW-1:0]   idx;
  logic              grp;
  logic [3:0]        k;
  gnd_off_t          off;
  logic [CoordW-1:0] base_col;
  logic [CoordW-1:0] base_row;

  // output register moves when empty or being taken
  assign adv = !out_valid_q || pop_i;

  // lowest pending cell
  always_comb begin
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (job_q.mask[i]) idx = IdxW'(i);
    end
  end

  assign low = job_q.mask & (~job_q.mask + gnd_mask_t'(1));
  assign rem = job_q.mask & ~low;

  // cell coordinates of the chosen bit
  always_comb begin
    grp      = (idx >= IdxW'(NbrCells));
    k        = grp ? 4'(idx - IdxW'(NbrCells)) : 4'(idx);
    off      = cell_off(k);
    base_col = grp ? job_q.old_col : job_q.new_col;
    base_row = grp ? job_q.old_row : job_q.new_row;
  end

  // take the next job as soon as the current one hands out its final cell
  assign emit   = adv && busy_q;
  assign load   = adv && q_valid_i && (!busy_q || (rem == '0));
  assign q_rd_o = load;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= busy_q;
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit) begin
        busy_q <= (rem != '0);
      end
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_job_i;
    end else if (emit) begin
      job_q.mask <= rem;
    end
    if (emit) begin
      cell_col_o <= base_col + CoordW'(off.dx) - CoordW'(1);
      cell_row_o <= base_row + CoordW'(off.dy) - CoordW'(1);
      leaving_o  <= grp;
      last_o     <= (rem == '0);
    end
  end

  assign empty_o = !out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_neighbourhood_diff.sv =====
// path: job queue, then the back end's job register, then its result register
// throughput: one move transferred per cycle while the job queue has room;
//   the back end gives 1 to 18 results per move, one per cycle while they are taken
// moves whose neighbourhoods give no change leave no job
// reset: asynchronous active low; clears the queues and sets both grid sizes to 1
`default_nettype none

module grid_neighbourhood_diff
  import gnd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = DefFifoDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [DimW-1:0]   cfg_wdata_i,
  // input side
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CoordW-1:0] old_col_i,
  input  wire logic [CoordW-1:0] old_row_i,
  input  wire logic [CoordW-1:0] new_col_i,
  input  wire logic [CoordW-1:0] new_row_i,
  // result side
  output logic                   empty,
  input  wire logic              pop,
  output logic [CoordW-1:0]      cell_col_o,
  output logic [CoordW-1:0]      cell_row_o,
  output logic                   leaving_o,
  output logic                   last_o
);

  logic     q_wr;
  logic     q_rd;
  logic     q_valid;
  gnd_job_t q_wjob;
  gnd_job_t q_rjob;

  // classify moves
  gnd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .old_col_i   (old_col_i),
    .old_row_i   (old_row_i),
    .new_col_i   (new_col_i),
    .new_row_i   (new_row_i),
    .q_full_i    (full),
    .q_wr_o      (q_wr),
    .q_job_o     (q_wjob)
  );

  // job queue
  gnd_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wjob),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_rjob),
    .valid_o (q_valid)
  );

  // hand out results
  gnd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (q_rjob),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .cell_col_o (cell_col_o),
    .cell_row_o (cell_row_o),
    .leaving_o  (leaving_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gnd_checker.sv =====
// port-level checks for the neighbourhood diff block, bound to its top level
// depends on gnd_pkg
`default_nettype none

module gnd_checker
  import gnd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_we_i,
  input wire logic [0:0]        cfg_idx_i,
  input wire logic [DimW-1:0]   cfg_wdata_i,
  input wire logic              push,
  input wire logic              full,
  input wire logic [CoordW-1:0] old_col_i,
  input wire logic [CoordW-1:0] old_row_i,
  input wire logic [CoordW-1:0] new_col_i,
  input wire logic [CoordW-1:0] new_row_i,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [CoordW-1:0] cell_col_o,
  input wire logic [CoordW-1:0] cell_row_o,
  input wire logic              leaving_o,
  input wire logic              last_o
);

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(cell_col_o) && $stable(cell_row_o) &&
                          $stable(leaving_o) && $stable(last_o)))
    else $error("result changed while waiting");

  // results of one move come back to back
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a run of results");

  // added cells never follow removed cells of the same move
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && leaving_o && !last_o) |=> leaving_o)
    else $error("added cell after a removed cell");

  // nothing to hand out right after reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not clear after reset");

endmodule

bind grid_neighbourhood_diff gnd_checker u_gnd_checker (.*);

`default_nettype wire
